// ===== src/msvf_pkg.sv =====
package msvf_pkg;

	localparam int TAN_DEPTH_DEF = 1024;
	localparam int EXP_DEPTH_DEF = 256;

	localparam int SR_W   = 18;
	localparam int BASE_W = 17;
	localparam int RQ_W   = 16;
	localparam int SMP_W  = 16;
	localparam int MOD_W  = 16;
	localparam int ADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam int FREQ_W = 42;
	localparam int MA_W   = 50;
	localparam int MB_W   = 34;
	localparam int MAG_W  = 39;
	localparam int ACC_W  = MAG_W + MB_W;
	localparam int DIV_W  = 64;
	localparam int QUO_W  = 33;
	localparam int CNT_W  = 6;

	typedef enum logic [1:0] {
		REG_SAMPLE_RATE = 2'd0,
		REG_BASE_CUTOFF = 2'd1,
		REG_RESONANCE   = 2'd2
	} msvf_reg_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_EXP,
		OP_FREQ,
		OP_NUM,
		OP_TCAP,
		OP_TDIV_GO,
		OP_TDIV_END,
		OP_TAN,
		OP_DDIV_END,
		OP_FR_GO,
		OP_FR_END,
		OP_G_END,
		OP_A_END,
		OP_HP_END,
		OP_V1_END,
		OP_V2_END,
		OP_OUT
	} msvf_op_t;

	typedef struct packed {
		logic tcap;
		logic div_done;
		logic mul_done;
	} msvf_stat_t;

endpackage

// ===== src/msvf_div.sv =====
module msvf_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [msvf_pkg::DIV_W-1:0]    num,
	input  logic [msvf_pkg::DIV_W-1:0]    dsh,
	input  logic [msvf_pkg::CNT_W-1:0]    steps,
	output logic [msvf_pkg::QUO_W-1:0]    quo,
	output logic                          done
);
	import msvf_pkg::*;

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dsh_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             ge;

	assign ge = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring divide, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= dsh;
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[QUO_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

// ===== src/msvf_mul.sv =====
module msvf_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [msvf_pkg::MA_W-1:0]    a,
	input  logic [msvf_pkg::MB_W-1:0]           b,
	output logic signed [msvf_pkg::MA_W-1:0]    res,
	output logic                                done
);
	import msvf_pkg::*;

	localparam int HB = MB_W / 2;
	localparam logic [MA_W-1:0] MAG_LIMIT = MA_W'({MAG_W{1'b1}});

	logic [MA_W-1:0]         a_abs;
	logic [MAG_W-1:0]        a_mag;
	logic [MAG_W-1:0]        m_q;
	logic                    neg_q;
	logic [MB_W-1:0]         b_q;
	logic [ACC_W-1:0]        acc_q;
	logic signed [MA_W-1:0]  res_q;
	logic [1:0]              step_q;
	logic                    done_q;
	logic [ACC_W-25:0]       pm;

	assign a_abs = a[MA_W-1] ? MA_W'(-a) : MA_W'(a);
	assign a_mag = (a_abs > MAG_LIMIT) ? MAG_W'(MAG_LIMIT) : a_abs[MAG_W-1:0];
	assign pm    = acc_q[ACC_W-1:24];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 2'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= 2'd1;
			end else if (step_q != 2'd0) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// two partial products of the magnitude, then scale by 2^-24
	always_ff @(posedge clk) begin
		if (start) begin
			m_q   <= a_mag;
			neg_q <= a[MA_W-1];
			b_q   <= b;
		end else begin
			case (step_q)
				2'd1: begin
					acc_q <= ACC_W'(m_q) * ACC_W'(b_q[HB-1:0]);
				end
				2'd2: begin
					acc_q <= acc_q + ((ACC_W'(m_q) * ACC_W'(b_q[MB_W-1:HB])) << HB);
				end
				2'd3: begin
					res_q <= neg_q ? -MA_W'(pm) : MA_W'(pm);
				end
				default: begin
				end
			endcase
		end
	end

	assign res  = res_q;
	assign done = done_q;

endmodule

// ===== src/msvf_ctrl.sv =====
module msvf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  msvf_pkg::msvf_stat_t  stat,
	output msvf_pkg::msvf_op_t    op
);
	import msvf_pkg::*;

	typedef enum logic [15:0] {
		ST_IDLE  = 16'b0000_0000_0000_0001,
		ST_EXP   = 16'b0000_0000_0000_0010,
		ST_FREQ  = 16'b0000_0000_0000_0100,
		ST_NUM   = 16'b0000_0000_0000_1000,
		ST_TCHK  = 16'b0000_0000_0001_0000,
		ST_TDIV  = 16'b0000_0000_0010_0000,
		ST_TAN   = 16'b0000_0000_0100_0000,
		ST_DDIV  = 16'b0000_0000_1000_0000,
		ST_FRGO  = 16'b0000_0001_0000_0000,
		ST_FRMUL = 16'b0000_0010_0000_0000,
		ST_GDIV  = 16'b0000_0100_0000_0000,
		ST_AMUL  = 16'b0000_1000_0000_0000,
		ST_HPMUL = 16'b0001_0000_0000_0000,
		ST_V1MUL = 16'b0010_0000_0000_0000,
		ST_V2MUL = 16'b0100_0000_0000_0000,
		ST_DONE  = 16'b1000_0000_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		op      = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					op      = OP_LOAD;
					state_d = ST_EXP;
				end
			end
			ST_EXP: begin
				op      = OP_EXP;
				state_d = ST_FREQ;
			end
			ST_FREQ: begin
				op      = OP_FREQ;
				state_d = ST_NUM;
			end
			ST_NUM: begin
				op      = OP_NUM;
				state_d = ST_TCHK;
			end
			ST_TCHK: begin
				if (stat.tcap) begin
					op      = OP_TCAP;
					state_d = ST_TAN;
				end else begin
					op      = OP_TDIV_GO;
					state_d = ST_TDIV;
				end
			end
			ST_TDIV: begin
				if (stat.div_done) begin
					op      = OP_TDIV_END;
					state_d = ST_TAN;
				end
			end
			ST_TAN: begin
				op      = OP_TAN;
				state_d = ST_DDIV;
			end
			ST_DDIV: begin
				if (stat.div_done) begin
					op      = OP_DDIV_END;
					state_d = ST_FRGO;
				end
			end
			ST_FRGO: begin
				op      = OP_FR_GO;
				state_d = ST_FRMUL;
			end
			ST_FRMUL: begin
				if (stat.mul_done) begin
					op      = OP_FR_END;
					state_d = ST_GDIV;
				end
			end
			ST_GDIV: begin
				if (stat.div_done) begin
					op      = OP_G_END;
					state_d = ST_AMUL;
				end
			end
			ST_AMUL: begin
				if (stat.mul_done) begin
					op      = OP_A_END;
					state_d = ST_HPMUL;
				end
			end
			ST_HPMUL: begin
				if (stat.mul_done) begin
					op      = OP_HP_END;
					state_d = ST_V1MUL;
				end
			end
			ST_V1MUL: begin
				if (stat.mul_done) begin
					op      = OP_V1_END;
					state_d = ST_V2MUL;
				end
			end
			ST_V2MUL: begin
				if (stat.mul_done) begin
					op      = OP_V2_END;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					op      = OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== src/msvf_dpath.sv =====
module msvf_dpath #(
	parameter int TAN_DEPTH = msvf_pkg::TAN_DEPTH_DEF,
	parameter int EXP_DEPTH = msvf_pkg::EXP_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  msvf_pkg::msvf_op_t                  op,
	output msvf_pkg::msvf_stat_t                stat,
	input  logic signed [msvf_pkg::SMP_W-1:0]   sample_in,
	input  logic [msvf_pkg::MOD_W-1:0]          mod_octaves,
	input  logic [msvf_pkg::SR_W-1:0]           sample_rate_hz,
	input  logic [msvf_pkg::BASE_W-1:0]         base_cutoff_hz,
	input  logic [msvf_pkg::RQ_W-1:0]           resonance_q,
	output logic signed [msvf_pkg::SMP_W-1:0]   lowpass_out
);
	import msvf_pkg::*;

	localparam int TIW   = $clog2(TAN_DEPTH);
	localparam int EIW   = $clog2(EXP_DEPTH);
	localparam int TCAP  = (98 * TAN_DEPTH) / 100;
	localparam int QW    = $clog2(TCAP + 1);
	localparam int NUM_W = FREQ_W + $clog2(2 * TAN_DEPTH) + 1;
	localparam int EP_W  = 12 + EIW + 1;
	localparam int FP_W  = BASE_W + 32;
	localparam int DEN_W = 40;
	localparam int G_W   = 25;
	localparam int SUM_W = MA_W + 1;
	localparam logic [63:0] ONE_Q30 = 64'd1073741824;
	localparam logic [63:0] LN2_Q30 = 64'd744261118;

	typedef logic [31:0] tan_rom_t [TAN_DEPTH];
	typedef logic [31:0] exp_rom_t [EXP_DEPTH];

	// shift-subtract quotient for the table builders
	function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
		logic [63:0] q;
		logic [64:0] rem;
		q   = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], n[b]};
			if (rem >= {1'b0, d}) begin
				rem  = rem - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// 2^(i/depth) in Q2.30, Taylor sum of e^y to order 12
	function automatic exp_rom_t exp_build();
		exp_rom_t    t;
		logic [63:0] y;
		logic [63:0] term;
		logic [63:0] sum;
		for (int i = 0; i < EXP_DEPTH; i++) begin
			y    = udiv64(64'(i) * LN2_Q30, 64'(EXP_DEPTH));
			term = ONE_Q30;
			sum  = ONE_Q30;
			for (int n = 1; n <= 12; n++) begin
				term = udiv64((term * y) >> 30, 64'(n));
				sum  = sum + term;
			end
			t[i] = sum[31:0];
		end
		return t;
	endfunction

	// tan(3.14*i/(2*depth)) in Q24 from sin and cos Taylor sums in Q30
	function automatic tan_rom_t tan_build();
		tan_rom_t           t;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        st;
		logic [63:0]        ct;
		logic [63:0]        qt;
		logic signed [63:0] s;
		logic signed [63:0] c;
		for (int i = 0; i < TAN_DEPTH; i++) begin
			x  = udiv64(64'd314 * ONE_Q30 * 64'(i), 64'd200 * 64'(TAN_DEPTH));
			x2 = (x * x) >> 30;
			st = x;
			ct = ONE_Q30;
			s  = signed'(x);
			c  = signed'(ONE_Q30);
			for (int k = 1; k <= 7; k++) begin
				st = udiv64((st * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
				ct = udiv64((ct * x2) >> 30, 64'((2 * k - 1) * (2 * k)));
				if (k[0]) begin
					s = s - signed'(st);
					c = c - signed'(ct);
				end else begin
					s = s + signed'(st);
					c = c + signed'(ct);
				end
			end
			if (s < 0) begin
				s = 0;
			end
			if (c <= 0) begin
				t[i] = 32'hFFFF_FFFF;
			end else begin
				qt   = udiv64(64'(s) << 24, 64'(c));
				t[i] = (qt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : qt[31:0];
			end
		end
		return t;
	endfunction

	localparam exp_rom_t EXP_ROM = exp_build();
	localparam tan_rom_t TAN_ROM = tan_build();

	logic signed [SMP_W-1:0] x_q;
	logic [MOD_W-1:0]        mod_q;
	logic [31:0]             exp_q;
	logic [FREQ_W-1:0]       freq_q;
	logic [NUM_W-1:0]        num_q;
	logic [TIW-1:0]          tidx_q;
	logic [31:0]             f_q;
	logic [MB_W-1:0]         r_q;
	logic [G_W-1:0]          g_q;
	logic signed [MA_W-1:0]  v1_q;
	logic signed [31:0]      z1_q;
	logic signed [31:0]      z2_q;
	logic signed [SMP_W-1:0] lp_q;
	logic signed [SMP_W-1:0] out_q;

	logic [EP_W-1:0]         eprod;
	logic [EIW-1:0]          eidx;
	logic [FP_W-1:0]         fprod;
	logic [FP_W-15:0]        fbase;
	logic [3:0]              octn;
	logic [FREQ_W-1:0]       freq_c;
	logic [DIV_W-1:0]        sr_lim;
	logic [RQ_W-1:0]         q_eff;
	logic [DEN_W-1:0]        den_g;

	logic                    div_go;
	logic [DIV_W-1:0]        div_num;
	logic [DIV_W-1:0]        div_dsh;
	logic [CNT_W-1:0]        div_steps;
	logic [QUO_W-1:0]        div_quo;
	logic                    div_done;

	logic                    mul_go;
	logic signed [MA_W-1:0]  mul_a;
	logic [MB_W-1:0]         mul_b;
	logic signed [MA_W-1:0]  mul_res;
	logic                    mul_done;

	logic signed [MA_W-1:0]  x28;
	logic signed [SUM_W-1:0] z1n;
	logic signed [SUM_W-1:0] z2n;
	logic signed [SUM_W-1:0] lp;
	logic signed [SUM_W-1:0] lp_sh;
	logic [31:0]             z1_sat;
	logic [31:0]             z2_sat;
	logic [SMP_W-1:0]        lp_sat;

	assign eprod  = EP_W'(mod_q[11:0]) * EP_W'(EXP_DEPTH);
	assign eidx   = eprod[12 +: EIW];
	assign fprod  = FP_W'(base_cutoff_hz) * FP_W'(exp_q);
	assign fbase  = fprod[FP_W-1:14];
	assign octn   = 4'(4'd0 - mod_q[15:12]);
	assign freq_c = mod_q[15] ? (FREQ_W'(fbase) >> octn) : (FREQ_W'(fbase) << mod_q[14:12]);
	assign sr_lim = DIV_W'(sample_rate_hz) << (16 + QW);
	assign q_eff  = (resonance_q == '0) ? RQ_W'(1) : resonance_q;
	assign den_g  = DEN_W'(mul_res) + (DEN_W'(1) << 24);

	assign stat.tcap     = (sample_rate_hz == '0) || (DIV_W'(num_q) >= sr_lim);
	assign stat.div_done = div_done;
	assign stat.mul_done = mul_done;

	assign x28 = MA_W'(x_q) <<< 13;
	assign z1n = SUM_W'(z1_q) + (SUM_W'(v1_q) <<< 1);
	assign z2n = SUM_W'(z2_q) + (SUM_W'(mul_res) <<< 1);
	assign lp  = SUM_W'(z2_q) + SUM_W'(mul_res);
	assign lp_sh = lp >>> 13;

	always_comb begin
		if ((z1n[SUM_W-1:31] == '0) || (z1n[SUM_W-1:31] == '1)) begin
			z1_sat = z1n[31:0];
		end else begin
			z1_sat = z1n[SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		if ((z2n[SUM_W-1:31] == '0) || (z2n[SUM_W-1:31] == '1)) begin
			z2_sat = z2n[31:0];
		end else begin
			z2_sat = z2n[SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		if ((lp_sh[SUM_W-1:15] == '0) || (lp_sh[SUM_W-1:15] == '1)) begin
			lp_sat = lp_sh[15:0];
		end else begin
			lp_sat = lp_sh[SUM_W-1] ? 16'h8000 : 16'h7FFF;
		end
	end

	always_comb begin
		div_go    = 1'b0;
		div_num   = DIV_W'(num_q);
		div_dsh   = DIV_W'(sample_rate_hz) << (16 + QW - 1);
		div_steps = CNT_W'(QW);
		case (op)
			OP_TDIV_GO: begin
				div_go = 1'b1;
			end
			OP_TAN: begin
				div_go    = 1'b1;
				div_num   = DIV_W'(1) << 32;
				div_dsh   = DIV_W'(q_eff) << 32;
				div_steps = CNT_W'(33);
			end
			OP_FR_END: begin
				div_go    = 1'b1;
				div_num   = DIV_W'(1) << 48;
				div_dsh   = DIV_W'(den_g) << 24;
				div_steps = CNT_W'(G_W);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		mul_go = 1'b0;
		mul_a  = mul_res;
		mul_b  = MB_W'(f_q);
		case (op)
			OP_FR_GO: begin
				mul_go = 1'b1;
				mul_a  = MA_W'(signed'({1'b0, f_q}));
				mul_b  = r_q;
			end
			OP_G_END: begin
				mul_go = 1'b1;
				mul_a  = MA_W'(z1_q);
				mul_b  = r_q;
			end
			OP_A_END: begin
				mul_go = 1'b1;
				mul_a  = x28 - mul_res - MA_W'(z2_q);
				mul_b  = MB_W'(g_q);
			end
			OP_HP_END: begin
				mul_go = 1'b1;
			end
			OP_V1_END: begin
				mul_go = 1'b1;
				mul_a  = MA_W'(z1_q) + mul_res;
			end
			default: begin
			end
		endcase
	end

	msvf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.num    (div_num),
		.dsh    (div_dsh),
		.steps  (div_steps),
		.quo    (div_quo),
		.done   (div_done)
	);

	msvf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_go),
		.a      (mul_a),
		.b      (mul_b),
		.res    (mul_res),
		.done   (mul_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z1_q <= '0;
			z2_q <= '0;
		end else if (op == OP_V2_END) begin
			z1_q <= signed'(z1_sat);
			z2_q <= signed'(z2_sat);
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				x_q   <= sample_in;
				mod_q <= mod_octaves;
			end
			OP_EXP: begin
				exp_q <= EXP_ROM[eidx];
			end
			OP_FREQ: begin
				freq_q <= freq_c;
			end
			OP_NUM: begin
				num_q <= NUM_W'(freq_q) * NUM_W'(2 * TAN_DEPTH);
			end
			OP_TCAP: begin
				tidx_q <= TIW'(TCAP);
			end
			OP_TDIV_END: begin
				tidx_q <= (div_quo > QUO_W'(TCAP)) ? TIW'(TCAP) : div_quo[TIW-1:0];
			end
			OP_TAN: begin
				f_q <= TAN_ROM[tidx_q];
			end
			OP_DDIV_END: begin
				r_q <= MB_W'(f_q) + MB_W'(div_quo);
			end
			OP_G_END: begin
				g_q <= div_quo[G_W-1:0];
			end
			OP_V1_END: begin
				v1_q <= mul_res;
			end
			OP_V2_END: begin
				lp_q <= signed'(lp_sat);
			end
			OP_OUT: begin
				out_q <= lp_q;
			end
			default: begin
			end
		endcase
	end

	assign lowpass_out = out_q;

endmodule

// ===== src/modulated_svf_lowpass.sv =====
// modulated state-variable lowpass, one trapezoidal filter step per sample
//
// s_axis carries one sample (sample_in, mod_octaves); m_axis returns one
// lowpass_out for every sample taken. registers sit on the apb port:
// sample_rate_hz at 0x0, base_cutoff_hz at 0x4, resonance_q at 0x8.
// write them only while no sample is in flight.
//
// each sample runs through setup steps (load, exp2 lookup, cutoff, tan
// numerator), then the shared restoring divider forms the tan index (if
// not capped) in clog2(tan index bound + 1) quotient bits, 1/q in 33 bits
// and g in 25 bits, and the shared multiplier forms five products.
// one sample is in work at a time.
//
// reset clears both integrators, loads the register defaults and empties
// the output register. a finished result waits in the output register
// while m_axis_tready is low; the next sample is still taken and worked on,
// and only its final transfer into the output register waits for room.
module modulated_svf_lowpass #(
	parameter int TAN_TABLE_DEPTH  = msvf_pkg::TAN_DEPTH_DEF,
	parameter int EXP2_TABLE_DEPTH = msvf_pkg::EXP_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [31:0]                          s_axis_tdata,  // sample_in, mod_octaves
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [15:0]                          m_axis_tdata,  // lowpass_out
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [msvf_pkg::ADDR_W-1:0]          paddr,
	input  logic [msvf_pkg::PDATA_W-1:0]         pwdata,
	output logic [msvf_pkg::PDATA_W-1:0]         prdata,
	output logic                                 pready
);
	import msvf_pkg::*;

	logic [SR_W-1:0]   sample_rate_hz_q;
	logic [BASE_W-1:0] base_cutoff_hz_q;
	logic [RQ_W-1:0]   resonance_q_q;
	logic              wr_en;
	msvf_reg_t         reg_sel;
	msvf_op_t          op;
	msvf_stat_t        stat;
	logic signed [SMP_W-1:0] lowpass_out;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = msvf_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_hz_q <= SR_W'(48000);
			base_cutoff_hz_q <= BASE_W'(8000);
			resonance_q_q    <= RQ_W'(512);
		end else if (wr_en) begin
			case (reg_sel)
				REG_SAMPLE_RATE: sample_rate_hz_q <= pwdata[SR_W-1:0];
				REG_BASE_CUTOFF: base_cutoff_hz_q <= pwdata[BASE_W-1:0];
				REG_RESONANCE:   resonance_q_q    <= pwdata[RQ_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_SAMPLE_RATE: prdata = PDATA_W'(sample_rate_hz_q);
			REG_BASE_CUTOFF: prdata = PDATA_W'(base_cutoff_hz_q);
			REG_RESONANCE:   prdata = PDATA_W'(resonance_q_q);
			default:         prdata = '0;
		endcase
	end

	msvf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.op        (op)
	);

	msvf_dpath #(
		.TAN_DEPTH (TAN_TABLE_DEPTH),
		.EXP_DEPTH (EXP2_TABLE_DEPTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (op),
		.stat           (stat),
		.sample_in      (signed'(s_axis_tdata[15:0])),
		.mod_octaves    (s_axis_tdata[31:16]),
		.sample_rate_hz (sample_rate_hz_q),
		.base_cutoff_hz (base_cutoff_hz_q),
		.resonance_q    (resonance_q_q),
		.lowpass_out    (lowpass_out)
	);

	assign m_axis_tdata = lowpass_out;

	// one sample in work at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input taken while a sample is in work");

	// a result never overwrites one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_OUT) |-> (!m_axis_tvalid || m_axis_tready))
		else $error("output register overwritten");

	// output valid rises only from a finished sample
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(op == OP_OUT))
		else $error("output valid without a finished sample");

endmodule

// ===== tb/tb_modulated_svf_lowpass.sv =====
module tb_modulated_svf_lowpass;
	import msvf_pkg::*;

	localparam int TAN_DEPTH = 1024;
	localparam int EXP_DEPTH = 256;
	localparam longint MAG_LIMIT = 64'sd549755813887;
	localparam int LAT_CYCLES = 200;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic signed [15:0] mod_octaves;
		logic signed [15:0] sample_in;
	} sample_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	modulated_svf_lowpass u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	longint unsigned exp_lut [EXP_DEPTH];
	longint unsigned tan_lut [TAN_DEPTH];
	longint unsigned rate_hz;
	longint unsigned cutoff_hz;
	longint unsigned res_q;
	longint signed lp_z1;
	longint signed lp_z2;

	sample_t sample_q[$];
	logic signed [15:0] lowpass_q[$];
	int errors;
	longint cycles;
	bit gap_pause;
	bit rx_hold;
	int rx_hold_cycles;

	initial begin
		clk = 1'b0;
	end

	always #10 clk = ~clk;

	function automatic void build_luts();
		longint unsigned y, term, sum, x, x2, st, ct, t;
		longint signed s, c;
		for (int i = 0; i < EXP_DEPTH; i++) begin
			y = longint'(i) * 64'd744261118 / EXP_DEPTH;
			term = 64'd1 << 30;
			sum = term;
			for (int n = 1; n <= 12; n++) begin
				term = ((term * y) >> 30) / n;
				sum += term;
			end
			exp_lut[i] = sum;
		end
		for (int i = 0; i < TAN_DEPTH; i++) begin
			x = (64'd314 * (64'd1 << 30) * i) / (64'd200 * TAN_DEPTH);
			x2 = (x * x) >> 30;
			st = x;
			ct = 64'd1 << 30;
			s = x;
			c = 64'sd1 << 30;
			for (int k = 1; k <= 7; k++) begin
				st = ((st * x2) >> 30) / ((2 * k) * (2 * k + 1));
				ct = ((ct * x2) >> 30) / ((2 * k - 1) * (2 * k));
				if (k & 1) begin
					s -= st;
					c -= ct;
				end else begin
					s += st;
					c += ct;
				end
			end
			if (s < 0) s = 0;
			if (c <= 0) tan_lut[i] = 64'hFFFF_FFFF;
			else begin
				t = (longint'(s) << 24) / longint'(c);
				tan_lut[i] = t > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : t;
			end
		end
	endfunction

	function automatic longint signed scale_q24(longint signed a, longint unsigned b);
		longint unsigned m, p;
		m = a < 0 ? -a : a;
		if (m > MAG_LIMIT) m = MAG_LIMIT;
		p = m * (b >> 24) + ((m * (b & 64'hFF_FFFF)) >> 24);
		return a < 0 ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint signed clip32(longint signed v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic logic signed [15:0] filter_step(sample_t smp);
		longint signed x, oct, hp, bp, lp, v1, v2, o;
		longint unsigned mu, frac, eidx, freq, tidx, cap, f, d, r, g, q;
		x = longint'(smp.sample_in) * 8192;
		mu = {48'd0, smp.mod_octaves} ^ 64'h8000;
		oct = longint'(mu >> 12) - 8;
		frac = mu & 64'hFFF;
		eidx = (frac * EXP_DEPTH) >> 12;
		if (eidx >= EXP_DEPTH) eidx = EXP_DEPTH - 1;
		freq = (cutoff_hz * exp_lut[eidx]) >> 14;
		if (oct >= 0) freq = freq << oct;
		else freq = freq >> (-oct);
		cap = (64'd98 * TAN_DEPTH) / 100;
		if (rate_hz == 0) tidx = cap;
		else begin
			tidx = (freq * 2 * TAN_DEPTH) / (rate_hz << 16);
			if (tidx > cap) tidx = cap;
		end
		f = tan_lut[tidx];
		q = res_q != 0 ? res_q : 1;
		d = (64'd1 << 32) / q;
		r = f + d;
		g = (64'd1 << 48) / (((f * r) >> 24) + (64'd1 << 24));
		hp = scale_q24(x - scale_q24(lp_z1, r) - lp_z2, g);
		v1 = scale_q24(hp, f);
		bp = lp_z1 + v1;
		v2 = scale_q24(bp, f);
		lp = lp_z2 + v2;
		lp_z1 = clip32(lp_z1 + 2 * v1);
		lp_z2 = clip32(lp_z2 + 2 * v2);
		if (lp >= 0) o = lp / 8192;
		else o = -((-lp + 8191) / 8192);
		if (o > 32767) o = 32767;
		if (o < -32768) o = -32768;
		return o[15:0];
	endfunction

	function automatic sample_t rand_sample(bit narrow_mod);
		sample_t s;
		s.sample_in = 16'($urandom);
		if (narrow_mod) s.mod_octaves = 16'($urandom_range(0, 16 * 4096) - 8 * 4096);
		else s.mod_octaves = 16'($urandom);
		return s;
	endfunction

	// sender: bursts and gaps
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				lowpass_q.push_back(filter_step(sample_t'(s_axis_tdata)));
			end
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (gap_left > 0) gap_left--;
				if (gap_pause || gap_left > 0 || sample_q.size() == 0) begin
					s_axis_tvalid <= 1'b0;
				end else begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= sample_q.pop_front();
					if (burst_left > 0) burst_left--;
					else begin
						burst_left = $urandom_range(0, 12);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
					end
				end
			end
		end
	end

	// receiver: own stall pattern, plus a long hold when asked
	int rx_mode;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_mode = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (lowpass_q.size() == 0) begin
					$display("%0t: unexpected lowpass_out %0d", $time,
						$signed(m_axis_tdata));
					errors++;
				end else begin
					if (lowpass_q[0] !== m_axis_tdata) begin
						$display("%0t: lowpass_out expected %0d actual %0d", $time,
							lowpass_q[0], $signed(m_axis_tdata));
						errors++;
					end
					void'(lowpass_q.pop_front());
				end
			end
			if ($urandom_range(0, 255) == 0) rx_mode = $urandom_range(0, 2);
			if (rx_hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				rx_hold_cycles--;
			end else if (rx_mode == 0) m_axis_tready <= 1'b1;
			else if (rx_mode == 1) m_axis_tready <= 1'($urandom_range(0, 1));
			else m_axis_tready <= ($urandom_range(0, 7) == 0);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_modulated_svf_lowpass NOT OK");
			$finish;
		end
	end

	task automatic reg_write(msvf_reg_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SAMPLE_RATE: rate_hz = val & 32'h3FFFF;
			REG_BASE_CUTOFF: cutoff_hz = val & 32'h1FFFF;
			default: res_q = val & 32'hFFFF;
		endcase
	endtask

	task automatic drain();
		while (sample_q.size() != 0 || s_axis_tvalid || lowpass_q.size() != 0)
			@(posedge clk);
		repeat (LAT_CYCLES) @(posedge clk);
	endtask

	task automatic queue_random(int n, bit narrow_mod);
		for (int i = 0; i < n; i++) sample_q.push_back(rand_sample(narrow_mod));
	endtask

	initial begin
		sample_t s;
		errors = 0;
		cycles = 0;
		gap_pause = 1'b0;
		rx_hold_cycles = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		build_luts();
		rate_hz = 48000;
		cutoff_hz = 8000;
		res_q = 512;
		lp_z1 = 0;
		lp_z2 = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// field extremes, octave extremes, cutoff clamp
		for (int a = 0; a < 4; a++) begin
			for (int b = 0; b < 5; b++) begin
				s.sample_in = (a == 0) ? 16'sh7FFF : (a == 1) ? 16'sh8000 :
					(a == 2) ? 16'sh0000 : 16'shFFFF;
				s.mod_octaves = (b == 0) ? 16'sh7FFF : (b == 1) ? 16'sh8000 :
					(b == 2) ? 16'sh0000 : (b == 3) ? 16'sh0FFF : 16'shF001;
				sample_q.push_back(s);
			end
		end
		drain();

		// extremes of the registers, zero rate and zero q
		reg_write(REG_SAMPLE_RATE, 0);
		reg_write(REG_RESONANCE, 0);
		reg_write(REG_BASE_CUTOFF, 96000);
		queue_random(5, 1'b0);
		drain();

		reg_write(REG_SAMPLE_RATE, 192000);
		reg_write(REG_BASE_CUTOFF, 1);
		reg_write(REG_RESONANCE, 65535);
		queue_random(150, 1'b1);
		// long receiver hold while items keep coming
		rx_hold_cycles = 3000;
		drain();

		reg_write(REG_SAMPLE_RATE, 8000);
		reg_write(REG_BASE_CUTOFF, 96000);
		reg_write(REG_RESONANCE, 16);
		queue_random(150, 1'b0);
		drain();

		reg_write(REG_SAMPLE_RATE, 32'hFFFF_FFFF);
		reg_write(REG_BASE_CUTOFF, 32'hFFFF_FFFF);
		reg_write(REG_RESONANCE, 32'hFFFF_FFFF);
		queue_random(100, 1'b0);
		drain();

		for (int p = 0; p < 4; p++) begin
			reg_write(REG_SAMPLE_RATE, $urandom_range(8000, 192000));
			reg_write(REG_BASE_CUTOFF, $urandom_range(1, 96000));
			reg_write(REG_RESONANCE, $urandom_range(16, 4096));
			queue_random(100, 1'b1);
			// sender pauses until every result is back
			while (sample_q.size() > 50) @(posedge clk);
			gap_pause = 1'b1;
			@(posedge clk);
			while (s_axis_tvalid || lowpass_q.size() != 0) @(posedge clk);
			gap_pause = 1'b0;
			queue_random(100, 1'($urandom_range(0, 1)));
			drain();
		end

		reg_write(REG_SAMPLE_RATE, 48000);
		reg_write(REG_BASE_CUTOFF, 8000);
		reg_write(REG_RESONANCE, 512);
		queue_random(100, 1'b1);
		drain();

		if (errors == 0) begin
			$display("tb_modulated_svf_lowpass OK");
		end else begin
			$display("tb_modulated_svf_lowpass NOT OK");
		end
		$finish;
	end

endmodule
